// File: rtl/acdw_pkg.sv
// Shared types, character codes and helpers of the ASCII command decoder.
package acdw_pkg;

	// Result kinds. KIND_TICK doubles as "no prefix" for prefix_kind().
	typedef enum logic [2:0] {
		KIND_TICK = 3'd0,
		KIND_MR   = 3'd1,
		KIND_ML   = 3'd2,
		KIND_S1   = 3'd3,
		KIND_S2   = 3'd4,
		KIND_S3   = 3'd5,
		KIND_WD   = 3'd6,
		KIND_NOK  = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ACK_NONE = 2'd0,
		ACK_OK   = 2'd1,
		ACK_NOK  = 2'd2
	} ack_t;

	// Configuration register indexes
	localparam logic CFG_MAX_SPEED = 1'b0;
	localparam logic CFG_TIMEOUT   = 1'b1;

	localparam logic [15:0] MAX_SPEED_RST = 16'd256;
	localparam logic [15:0] TIMEOUT_RST   = 16'd500;

	// Characters
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [15:0] PFX_MR = "MR";
	localparam logic [15:0] PFX_ML = "ML";
	localparam logic [15:0] PFX_S1 = "S1";
	localparam logic [15:0] PFX_S2 = "S2";
	localparam logic [15:0] PFX_S3 = "S3";
	localparam logic [15:0] PFX_WD = "WD";

	// Motor code range 0..310, centered on 155
	localparam logic [8:0] MOTOR_MAX = 9'd310;
	localparam logic [8:0] MOTOR_MID = 9'd155;
	// floor(2^32 / 155): reciprocal for the divide by 155
	localparam logic [24:0] RECIP_155 = 25'd27709466;

	// Decoded result of one word, before motor scaling
	typedef struct packed {
		kind_t              kind;
		ack_t               ack;
		logic [7:0]         mot_mag;   // |v - 155|
		logic               mot_neg;   // v below center
		logic signed [15:0] servo_angle;
		logic               alive;
	} acdw_res_t;

	function automatic logic is_space(logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic kind_t prefix_kind(logic [15:0] two);
		kind_t k;
		unique case (two)
			PFX_MR:  k = KIND_MR;
			PFX_ML:  k = KIND_ML;
			PFX_S1:  k = KIND_S1;
			PFX_S2:  k = KIND_S2;
			PFX_S3:  k = KIND_S3;
			PFX_WD:  k = KIND_WD;
			default: k = KIND_TICK;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/acdw_if.sv
// Valid/ready channel interfaces for the command words and result words.
interface acdw_cmd_if import acdw_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;

	modport source(output valid, func, rx_byte, input ready);
	modport sink(input valid, func, rx_byte, output ready);
endinterface

interface acdw_rsp_if import acdw_pkg::*; ();
	logic               valid;
	logic               ready;
	kind_t              kind;
	ack_t               ack;
	logic signed [16:0] motor_speed;
	logic signed [15:0] servo_angle;
	logic               alive;

	modport source(output valid, kind, ack, motor_speed, servo_angle, alive, input ready);
	modport sink(input valid, kind, ack, motor_speed, servo_angle, alive, output ready);
endinterface

// File: rtl/ascii_command_decoder_with_watchdog_unit.sv
// Top level of the ASCII command decoder with heartbeat watchdog.
// Path: a result word is held in the input register, decoded by the parser, then moves
//   through scaling registers s2, s3 and s4 (the output register); rsp.ready can stall each.
// Throughput: one word per cycle unless rsp stalls; no-result bytes skip the scaler.
// The divide by 155 is a reciprocal multiply plus one correction, spread over the stages.
// Reset (arst_n low, async): line parser idle, watchdog value/count cleared, alive low,
//   max_speed = 256, timeout_ticks = 500, pipeline empty.
module ascii_command_decoder_with_watchdog_unit import acdw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	acdw_cmd_if.sink    cmd,
	acdw_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] max_speed_q;
	logic [15:0] timeout_q;

	// input register
	logic       v_s1;
	logic       func_s1;
	logic [7:0] byte_s1;

	logic      has_res;
	acdw_res_t res;
	logic      scale_rdy;
	logic      s1_adv;

	// a word leaves s1 when it gives no result or the scaler takes it
	assign s1_adv    = v_s1 && (!has_res || scale_rdy);
	assign cmd.ready = !v_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_SPEED: max_speed_q <= cfg_wdata;
				CFG_TIMEOUT:   timeout_q   <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (cmd.ready)
			v_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_s1 <= cmd.func;
			byte_s1 <= cmd.rx_byte;
		end
	end

	// parse state and watchdog update as the word leaves s1
	acdw_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_v        (v_s1),
		.func          (func_s1),
		.rx_byte       (byte_s1),
		.adv           (s1_adv),
		.timeout_ticks (timeout_q),
		.has_res       (has_res),
		.res           (res)
	);

	acdw_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_v      (has_res),
		.in_rdy    (scale_rdy),
		.in_res    (res),
		.max_speed (max_speed_q),
		.rsp       (rsp)
	);

	// OK is only ever sent for motor and servo commands
	a_ack_ok_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.ack == ACK_OK)) |->
		((rsp.kind == KIND_MR) || (rsp.kind == KIND_ML) || (rsp.kind == KIND_S1) ||
		 (rsp.kind == KIND_S2) || (rsp.kind == KIND_S3)))
		else $error("OK reply on a non-motor, non-servo word");

	// speed field is zero unless the word is a motor command
	a_speed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.kind != KIND_MR) && (rsp.kind != KIND_ML)) |->
		(rsp.motor_speed == 17'sd0))
		else $error("motor speed set on a non-motor word");

	// scaled speed never exceeds the configured full scale
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |->
		((rsp.motor_speed <= $signed({1'b0, max_speed_q})) &&
		 (rsp.motor_speed >= -$signed({1'b0, max_speed_q}))))
		else $error("motor speed beyond max_speed");

	// a word that gives a result is never dropped from s1 while the scaler is full
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && has_res && !scale_rdy) |=> (v_s1 && $stable(byte_s1) && $stable(func_s1)))
		else $error("result word lost at the input register");

endmodule

// File: rtl/acdw_parser.sv
// Line parser, watchdog state: decodes one word per cycle while adv is set.
module acdw_parser import acdw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_v,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	input  logic        adv,
	input  logic [15:0] timeout_ticks,
	output logic        has_res,
	output acdw_res_t   res
);

	typedef enum logic [2:0] {
		PH_LEAD, PH_CMD1, PH_CMD2, PH_CMD3, PH_SIGN, PH_DIGITS, PH_DONE, PH_IGNORE
	} phase_t;

	phase_t      phase_q;
	logic [15:0] cmd_q;
	logic        neg_q;
	logic [31:0] acc_q;
	logic [31:0] wd_cur_q;
	logic [31:0] wd_prev_q;
	logic [15:0] ticks_q;
	logic        alive_q;

	logic               is_nl;
	logic               is_digit;
	logic [35:0]        acc_mul;
	logic [31:0]        acc_nxt;
	logic signed [31:0] val;
	logic [8:0]         vm;
	logic               changed;
	logic [15:0]        ticks_inc;
	logic               alive_tick;
	logic               line_live;
	kind_t              lk;

	assign is_nl    = !func && (rx_byte == CH_NL);
	assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);

	// saturating acc*10 + digit
	assign acc_mul = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, rx_byte[3:0]};
	assign acc_nxt = (acc_mul > 36'h0_8000_0000) ? 32'h8000_0000 : acc_mul[31:0];

	// magnitude is at most 2^31, so its negation always fits
	always_comb begin
		if (neg_q)
			val = $signed(32'(-acc_q));
		else if (acc_q[31])
			val = 32'sh7FFF_FFFF;
		else
			val = $signed(acc_q);
	end

	// motor code clamped to 0..310
	always_comb begin
		if (val < 0)
			vm = 9'd0;
		else if (val > $signed({23'b0, MOTOR_MAX}))
			vm = MOTOR_MAX;
		else
			vm = val[8:0];
	end

	assign changed    = wd_cur_q != wd_prev_q;
	assign ticks_inc  = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
	assign alive_tick = changed ? 1'b1 : ((ticks_inc > timeout_ticks) ? 1'b0 : alive_q);

	assign line_live = (phase_q != PH_LEAD) && (phase_q != PH_IGNORE);
	assign lk = ((phase_q == PH_SIGN) || (phase_q == PH_DIGITS) || (phase_q == PH_DONE))
		? prefix_kind(cmd_q) : KIND_TICK;

	always_comb begin
		res             = '0;
		res.kind        = KIND_TICK;
		res.ack         = ACK_NONE;
		res.alive       = alive_q;
		has_res         = 1'b0;
		if (func) begin
			has_res   = item_v;
			res.alive = alive_tick;
		end else if (is_nl) begin
			has_res  = item_v && line_live;
			res.kind = lk;
			unique case (lk)
				KIND_TICK: begin
					res.kind = KIND_NOK;
					res.ack  = ACK_NOK;
				end
				KIND_MR, KIND_ML: begin
					res.ack     = ACK_OK;
					res.mot_neg = vm < MOTOR_MID;
					res.mot_mag = (vm < MOTOR_MID) ? 8'(MOTOR_MID - vm) : 8'(vm - MOTOR_MID);
				end
				KIND_S1, KIND_S2, KIND_S3: begin
					res.ack = ACK_OK;
					if (val > 32'sd32767)
						res.servo_angle = 16'sh7FFF;
					else if (val < -32'sd32768)
						res.servo_angle = 16'sh8000;
					else
						res.servo_angle = val[15:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEAD;
			cmd_q     <= '0;
			neg_q     <= 1'b0;
			acc_q     <= '0;
			wd_cur_q  <= '0;
			wd_prev_q <= '0;
			ticks_q   <= '0;
			alive_q   <= 1'b0;
		end else if (adv) begin
			if (func) begin
				alive_q <= alive_tick;
				if (changed) begin
					wd_prev_q <= wd_cur_q;
					ticks_q   <= '0;
				end else begin
					ticks_q <= ticks_inc;
				end
			end else if (is_nl) begin
				if (line_live && (lk == KIND_WD))
					wd_cur_q <= val;
				phase_q <= PH_LEAD;
				cmd_q   <= '0;
				neg_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				unique case (phase_q)
					PH_LEAD: begin
						if (rx_byte == CH_COLON)
							phase_q <= PH_CMD1;
						else if (!is_space(rx_byte))
							phase_q <= PH_IGNORE;
					end
					PH_CMD1: begin
						cmd_q   <= {rx_byte, 8'h00};
						phase_q <= PH_CMD2;
					end
					PH_CMD2: begin
						cmd_q   <= {cmd_q[15:8], rx_byte};
						phase_q <= PH_CMD3;
					end
					PH_CMD3: begin
						if ((rx_byte == CH_EQ) && (prefix_kind(cmd_q) != KIND_TICK)) begin
							phase_q <= PH_SIGN;
						end else begin
							cmd_q   <= '0;
							phase_q <= PH_DONE;
						end
					end
					PH_SIGN, PH_DIGITS: begin
						if (is_digit) begin
							acc_q   <= acc_nxt;
							phase_q <= PH_DIGITS;
						end else if ((phase_q == PH_SIGN) && is_space(rx_byte)) begin
							phase_q <= PH_SIGN;
						end else if ((phase_q == PH_SIGN) &&
						             ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))) begin
							neg_q   <= rx_byte == CH_MINUS;
							phase_q <= PH_DIGITS;
						end else begin
							phase_q <= PH_DONE;
						end
					end
					PH_DONE, PH_IGNORE: ;
				endcase
			end
		end
	end

endmodule

// File: rtl/acdw_scale.sv
// Motor speed scaling pipeline: max_speed * mag / 155 by reciprocal multiply.
module acdw_scale import acdw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_v,
	output logic        in_rdy,
	input  acdw_res_t   in_res,
	input  logic [15:0] max_speed,
	acdw_rsp_if.source  rsp
);

	logic        v_s2, v_s3, v_s4;
	logic        rdy2, rdy3, rdy4;
	acdw_res_t   res_s2, res_s3;
	logic [23:0] p_s2, p_s3;
	logic [15:0] q0_s3;
	logic [48:0] prod;
	logic [23:0] back;
	logic [23:0] rem;
	logic [16:0] mag;

	kind_t              kind_s4;
	ack_t               ack_s4;
	logic signed [16:0] speed_s4;
	logic signed [15:0] angle_s4;
	logic               alive_s4;

	assign rdy4   = !v_s4 || rsp.ready;
	assign rdy3   = !v_s3 || rdy4;
	assign rdy2   = !v_s2 || rdy3;
	assign in_rdy = rdy2;

	// q0 is floor(p/155) or one less
	assign prod = p_s2 * RECIP_155;
	assign back = q0_s3 * 8'd155;
	assign rem  = p_s3 - back;
	assign mag  = {1'b0, q0_s3} + {16'b0, (rem[8:0] >= MOTOR_MID)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy2)
				v_s2 <= in_v;
			if (rdy3)
				v_s3 <= v_s2;
			if (rdy4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			res_s2 <= in_res;
			p_s2   <= max_speed * in_res.mot_mag;
		end
		if (rdy3) begin
			res_s3 <= res_s2;
			p_s3   <= p_s2;
			q0_s3  <= prod[47:32];
		end
		if (rdy4) begin
			kind_s4  <= res_s3.kind;
			ack_s4   <= res_s3.ack;
			angle_s4 <= res_s3.servo_angle;
			alive_s4 <= res_s3.alive;
			speed_s4 <= res_s3.mot_neg ? $signed(-mag) : $signed(mag);
		end
	end

	assign rsp.valid       = v_s4;
	assign rsp.kind        = kind_s4;
	assign rsp.ack         = ack_s4;
	assign rsp.motor_speed = speed_s4;
	assign rsp.servo_angle = angle_s4;
	assign rsp.alive       = alive_s4;

endmodule
